### hw/rtl/i2c_write_queue_sequencer_top_macros.svh
// assertion helpers for the write queue sequencer
`ifndef I2C_WRITE_QUEUE_SEQUENCER_TOP_MACROS_SVH
`define I2C_WRITE_QUEUE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define IWQS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iwqs check failed");

// next-cycle implication
`define IWQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iwqs check failed");

`endif

### hw/rtl/iwqs_pkg.sv
package iwqs_pkg;

  localparam int RING_DEPTH = 160;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int ENTRY_W    = 15;
  localparam int COUNT_OUT_W = 8;

  localparam logic [1:0] MODE_ENQ   = 2'd0;
  localparam logic [1:0] MODE_DISP  = 2'd1;
  localparam logic [1:0] MODE_EVENT = 2'd2;
  localparam logic [1:0] MODE_ERR   = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_ADDR  = 3'd2;
  localparam logic [2:0] ACT_DATA  = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [7:0] data_byte;
    logic       flag_start;
    logic       flag_addr_done;
    logic       flag_byte_done;
  } req_t;

  typedef struct packed {
    logic                   valid;
    logic [2:0]             action;
    logic [7:0]             out_byte;
    logic                   busy_res;
    logic                   dropped;
    logic [COUNT_OUT_W-1:0] queue_count;
  } res_t;

endpackage

### hw/rtl/iwqs_ram.sv
module iwqs_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 160,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/iwqs_ctrl.sv
module iwqs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [1:0]    mode,
  input  iwqs_pkg::req_t req,
  output logic          ready,
  output iwqs_pkg::res_t res
);
  import iwqs_pkg::*;

  typedef enum logic {ST_RUN, ST_POP} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_START, PH_ADDR, PH_DATA} phase_t;

  state_t             state;
  phase_t             phase;
  logic               in_flight;
  logic [ENTRY_W-1:0] current_entry;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   count;

  logic               wr_en;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;

  logic               full;
  logic               empty;
  logic [IDX_W-1:0]   head_next;
  logic [IDX_W-1:0]   tail_next;

  assign full      = (count == IDX_W'(RING_DEPTH - 1));
  assign empty     = (count == '0);
  assign head_next = (head == IDX_W'(RING_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_next = (tail == IDX_W'(RING_DEPTH - 1)) ? '0 : tail + 1'b1;
  assign ready     = (state == ST_RUN);
  assign wr_en     = go && (mode == MODE_ENQ) && !full;
  assign rd_en     = go && (mode == MODE_DISP) && !in_flight && !empty;

  iwqs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_DEPTH),
    .AW   (IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(tail),
    .wr_data({req.dev_addr, req.data_byte}),
    .rd_en  (rd_en),
    .rd_addr(head),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      phase         <= PH_IDLE;
      in_flight     <= 1'b0;
      current_entry <= '0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      res           <= '0;
    end else begin
      res.valid <= 1'b0;
      case (state)
        ST_RUN: begin
          if (go) begin
            res.valid    <= 1'b1;
            res.action   <= ACT_NONE;
            res.out_byte <= '0;
            res.dropped  <= 1'b0;
            res.busy_res <= in_flight;
            res.queue_count <= COUNT_OUT_W'(count);
            case (mode)
              MODE_ENQ: begin
                if (full) begin
                  res.dropped <= 1'b1;
                end else begin
                  tail            <= tail_next;
                  count           <= count + 1'b1;
                  res.queue_count <= COUNT_OUT_W'(count + 1'b1);
                end
              end
              MODE_DISP: begin
                if (rd_en) begin
                  res.valid <= 1'b0;
                  head      <= head_next;
                  count     <= count - 1'b1;
                  in_flight <= 1'b1;
                  phase     <= PH_START;
                  state     <= ST_POP;
                end
              end
              MODE_EVENT: begin
                if (req.flag_start && phase == PH_START) begin
                  res.action   <= ACT_ADDR;
                  res.out_byte <= {current_entry[14:8], 1'b0};
                  phase        <= PH_ADDR;
                end else if (req.flag_addr_done && phase == PH_ADDR) begin
                  res.action   <= ACT_DATA;
                  res.out_byte <= current_entry[7:0];
                  phase        <= PH_DATA;
                end else if (req.flag_byte_done && phase == PH_DATA) begin
                  res.action   <= ACT_STOP;
                  res.busy_res <= 1'b0;
                  in_flight    <= 1'b0;
                  phase        <= PH_IDLE;
                end
              end
              default: begin
                res.action   <= ACT_STOP;
                res.busy_res <= 1'b0;
                in_flight    <= 1'b0;
                phase        <= PH_IDLE;
              end
            endcase
          end
        end
        ST_POP: begin
          current_entry   <= rd_data;
          res.valid       <= 1'b1;
          res.action      <= ACT_START;
          res.out_byte    <= '0;
          res.busy_res    <= 1'b1;
          res.dropped     <= 1'b0;
          res.queue_count <= COUNT_OUT_W'(count);
          state           <= ST_RUN;
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

### hw/rtl/i2c_write_queue_sequencer_top.sv
// channel   dir  tdata fields (lsb up)                                      tuser
// s_axis    in   dev_addr, data_byte, flag_start, flag_addr_done,           mode
//                flag_byte_done
// m_axis    out  action, out_byte, busy_res, dropped, queue_count           -
//
// one result per transfer; it leaves through the ctrl result register and then the
// output register
// a dispatch that pops the ring first passes the ring memory read in ST_POP
// the input stalls while a result sits in the ctrl result register, while an untaken one
// sits in the output register, and during that ring read
// rst is synchronous; the ring contents are not cleared, only indexes, count, phase and state
module i2c_write_queue_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dev_addr[6:0], data_byte[14:7], flag_start[15], flag_addr_done[16],
  // flag_byte_done[17], zero fill[23:18]
  input  logic [23:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // action[2:0], out_byte[10:3], busy_res[11], dropped[12], queue_count[20:13],
  // zero fill[23:21]
  output logic [23:0] m_axis_tdata
);
  import iwqs_pkg::*;

  logic  ctrl_ready;
  logic  go;
  req_t  req;
  res_t  res;

  assign req.dev_addr       = s_axis_tdata[6:0];
  assign req.data_byte      = s_axis_tdata[14:7];
  assign req.flag_start     = s_axis_tdata[15];
  assign req.flag_addr_done = s_axis_tdata[16];
  assign req.flag_byte_done = s_axis_tdata[17];

  assign s_axis_tready = ctrl_ready && !res.valid && (!m_axis_tvalid || m_axis_tready);
  assign go            = s_axis_tvalid && s_axis_tready;

  iwqs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .mode (s_axis_tuser),
    .req  (req),
    .ready(ctrl_ready),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (res.valid) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {3'b000, res.queue_count, res.dropped, res.busy_res,
                          res.out_byte, res.action};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/iwqs_checker.sv
`include "i2c_write_queue_sequencer_top_macros.svh"

module iwqs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import iwqs_pkg::*;

  logic in_go;

  assign in_go  = s_axis_tvalid && s_axis_tready && (s_axis_tuser != MODE_DISP);

  // stalled result holds
  `IWQS_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  // a stop always leaves the bus free
  `IWQS_ASSERT_NOW(a_stop_free, clk, rst,
    m_axis_tvalid && m_axis_tdata[2:0] == ACT_STOP, !m_axis_tdata[11])

  // address or data sends only happen in flight
  `IWQS_ASSERT_NOW(a_send_busy, clk, rst,
    m_axis_tvalid && (m_axis_tdata[2:0] == ACT_ADDR || m_axis_tdata[2:0] == ACT_DATA),
    m_axis_tdata[11])

  // a dropped enqueue produces no bus action
  `IWQS_ASSERT_NOW(a_drop_none, clk, rst,
    m_axis_tvalid && m_axis_tdata[12], m_axis_tdata[2:0] == ACT_NONE)

  // non-dispatch transfers give a result through the ctrl result register and the output register
  `IWQS_ASSERT_NEXT(a_latency, clk, rst, $past(in_go), m_axis_tvalid)

endmodule

bind i2c_write_queue_sequencer_top iwqs_checker u_iwqs_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import iwqs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START_SENT,
    PH_ADDR_SENT,
    PH_DATA_SENT
  } xfer_phase_t;

  typedef struct {
    logic [1:0] mode;
    logic [6:0] dev_addr;
    logic [7:0] data_byte;
    logic       flag_start;
    logic       flag_addr_done;
    logic       flag_byte_done;
  } write_req_t;

  typedef struct {
    logic [2:0] action;
    logic [7:0] out_byte;
    logic       busy_res;
    logic       dropped;
    logic [7:0] queue_count;
  } bus_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = MODE_ENQ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  i2c_write_queue_sequencer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // sequencer shadow state
  logic [14:0] ring_entries [RING_DEPTH];
  logic [7:0]  ring_head = '0;
  logic [7:0]  ring_tail = '0;
  xfer_phase_t xfer_phase = PH_IDLE;
  logic        xfer_busy = 1'b0;
  logic [14:0] xfer_entry = '0;

  write_req_t stim_queue[$];
  bus_cmd_t   bus_cmds_due[$];
  int         stim_total = 0;
  int         accepted_count = 0;
  int         result_count = 0;
  int         error_count = 0;
  int         action_seen [5];
  int         drop_seen = 0;
  int         peak_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] ring_step(logic [7:0] idx);
    return (idx == RING_DEPTH - 1) ? 8'd0 : idx + 8'd1;
  endfunction

  function automatic bus_cmd_t step_sequencer(write_req_t req);
    bus_cmd_t cmd;
    cmd.action   = ACT_NONE;
    cmd.out_byte = '0;
    cmd.dropped  = 1'b0;
    case (req.mode)
      MODE_ENQ: begin
        if (ring_step(ring_tail) == ring_head) begin
          cmd.dropped = 1'b1;
        end else begin
          ring_entries[ring_tail] = {req.dev_addr, req.data_byte};
          ring_tail = ring_step(ring_tail);
        end
      end
      MODE_DISP: begin
        if (!xfer_busy && ring_head != ring_tail) begin
          xfer_entry = ring_entries[ring_head];
          ring_head  = ring_step(ring_head);
          xfer_busy  = 1'b1;
          xfer_phase = PH_START_SENT;
          cmd.action = ACT_START;
        end
      end
      MODE_EVENT: begin
        // one phase step per transfer, flags checked in phase order
        if (req.flag_start && xfer_phase == PH_START_SENT) begin
          cmd.out_byte = {xfer_entry[14:8], 1'b0};
          cmd.action   = ACT_ADDR;
          xfer_phase   = PH_ADDR_SENT;
        end else if (req.flag_addr_done && xfer_phase == PH_ADDR_SENT) begin
          cmd.out_byte = xfer_entry[7:0];
          cmd.action   = ACT_DATA;
          xfer_phase   = PH_DATA_SENT;
        end else if (req.flag_byte_done && xfer_phase == PH_DATA_SENT) begin
          cmd.action = ACT_STOP;
          xfer_busy  = 1'b0;
          xfer_phase = PH_IDLE;
        end
      end
      default: begin
        cmd.action = ACT_STOP;
        xfer_busy  = 1'b0;
        xfer_phase = PH_IDLE;
      end
    endcase
    cmd.busy_res    = xfer_busy;
    cmd.queue_count = 8'((int'(ring_tail) + RING_DEPTH - int'(ring_head)) % RING_DEPTH);
    return cmd;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  task automatic add_req(logic [1:0] mode, logic [6:0] dev_addr, logic [7:0] data_byte,
                         logic fs, logic fa, logic fb);
    write_req_t req;
    req.mode           = mode;
    req.dev_addr       = dev_addr;
    req.data_byte      = data_byte;
    req.flag_start     = fs;
    req.flag_addr_done = fa;
    req.flag_byte_done = fb;
    stim_queue.push_back(req);
    stim_total++;
  endtask

  task automatic add_random(logic [1:0] mode);
    add_req(mode, 7'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // write request driver, bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    write_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (stim_queue.size() != 0) begin
        req = stim_queue.pop_front();
        s_axis_tdata  <= {6'b0, req.flag_byte_done, req.flag_addr_done, req.flag_start,
                          req.data_byte, req.dev_addr};
        s_axis_tuser  <= req.mode;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: changing stall patterns plus one long hold-off
  int rx_taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int pat_sel = 0;
  int pat_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        rx_taken++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && rx_taken >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_sel  = $urandom_range(0, 2);
          pat_left = $urandom_range(10, 80);
        end else begin
          pat_left--;
        end
        case (pat_sel)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: check each result transfer, then predict for each accepted request
  always @(posedge clk) begin
    write_req_t req;
    bus_cmd_t   want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (bus_cmds_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = bus_cmds_due.pop_front();
          check_field("action", want.action, m_axis_tdata[2:0]);
          check_field("out_byte", want.out_byte, m_axis_tdata[10:3]);
          check_field("busy_res", want.busy_res, m_axis_tdata[11]);
          check_field("dropped", want.dropped, m_axis_tdata[12]);
          check_field("queue_count", want.queue_count, m_axis_tdata[20:13]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        accepted_count++;
        req.mode           = s_axis_tuser;
        req.dev_addr       = s_axis_tdata[6:0];
        req.data_byte      = s_axis_tdata[14:7];
        req.flag_start     = s_axis_tdata[15];
        req.flag_addr_done = s_axis_tdata[16];
        req.flag_byte_done = s_axis_tdata[17];
        want = step_sequencer(req);
        action_seen[want.action]++;
        if (want.dropped)
          drop_seen++;
        if (want.queue_count > peak_count)
          peak_count = want.queue_count;
        bus_cmds_due.push_back(want);
      end
    end
  end

  initial begin
    int pick;
    int n;
    bit fill_done;
    fill_done = 1'b0;

    // directed
    add_req(MODE_ERR, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_DISP, 7'h7f, 8'hff, 1'b1, 1'b1, 1'b1);
    add_req(MODE_EVENT, 7'h7f, 8'hff, 1'b1, 1'b1, 1'b1);
    add_req(MODE_ENQ, 7'h7f, 8'hff, 1'b1, 1'b1, 1'b1);
    add_req(MODE_ENQ, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_DISP, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_DISP, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b1, 1'b1);
    add_req(MODE_EVENT, 7'h00, 8'h00, 1'b1, 1'b1, 1'b1);
    add_req(MODE_EVENT, 7'h00, 8'h00, 1'b1, 1'b0, 1'b0);
    add_req(MODE_EVENT, 7'h00, 8'h00, 1'b1, 1'b1, 1'b1);
    add_req(MODE_EVENT, 7'h00, 8'h00, 1'b1, 1'b1, 1'b1);
    add_req(MODE_DISP, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_EVENT, 7'h00, 8'h00, 1'b1, 1'b0, 1'b0);
    add_req(MODE_ERR, 7'h7f, 8'hff, 1'b1, 1'b1, 1'b1);
    add_req(MODE_DISP, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_ENQ, 7'h55, 8'haa, 1'b0, 1'b0, 1'b0);
    add_req(MODE_DISP, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_ERR, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_ENQ, 7'h2a, 8'h55, 1'b0, 1'b0, 1'b0);
    add_req(MODE_DISP, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    add_req(MODE_EVENT, 7'h00, 8'h00, 1'b1, 1'b0, 1'b0);
    add_req(MODE_EVENT, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0);
    add_req(MODE_ERR, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0);

    // random: mostly complete transactions, with enqueue bursts and noise
    while (stim_total < 1225) begin
      pick = $urandom_range(0, 99);
      if (!fill_done && stim_total > 500) begin
        // overfill the ring so enqueues get dropped
        fill_done = 1'b1;
        repeat (170) add_random(MODE_ENQ);
      end else if (pick < 45) begin
        add_random(MODE_DISP);
        for (int step = 0; step < 3; step++) begin
          if ($urandom_range(0, 99) < 8) begin
            add_random(MODE_ERR);
            break;
          end
          add_req(MODE_EVENT, 7'($urandom), 8'($urandom),
                  (step == 0) ? 1'b1 : 1'($urandom),
                  (step == 1) ? 1'b1 : 1'($urandom),
                  (step == 2) ? 1'b1 : 1'($urandom));
        end
      end else if (pick < 70) begin
        n = $urandom_range(1, 6);
        repeat (n) add_random(MODE_ENQ);
      end else if (pick < 90) begin
        n = $urandom_range(1, 4);
        repeat (n) add_random(2'($urandom));
      end else begin
        add_random(MODE_DISP);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < stim_total || bus_cmds_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d dropped enqueues, ring peak %0d",
             accepted_count, result_count, drop_seen, peak_count);
    $display("actions: none %0d start %0d address %0d data %0d stop %0d",
             action_seen[0], action_seen[1], action_seen[2], action_seen[3], action_seen[4]);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", bus_cmds_due.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/iwqs_pkg.sv
hw/rtl/iwqs_ram.sv
hw/rtl/iwqs_ctrl.sv
hw/rtl/i2c_write_queue_sequencer_top.sv
hw/rtl/iwqs_checker.sv
verif/tb.sv
